// ===== src/gray_to_color_formula_defines.svh =====
// assertion macros for the gray to color formula unit
`ifndef GRAY_TO_COLOR_FORMULA_DEFINES_SVH
`define GRAY_TO_COLOR_FORMULA_DEFINES_SVH

// implication checked on every clock edge outside reset
`define G2C_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("g2c check failed");

// implication with a fixed latency in cycles
`define G2C_ASSERT_LAT(label, ante, lat, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##lat (cons)) \
		else $error("g2c latency check failed");

`endif

// ===== src/g2c_pkg.sv =====
`timescale 1ns / 1ps
package g2c_pkg;
	localparam int VAL_W = 17;
	localparam int SEL_W = 7;
	localparam logic [SEL_W-1:0] SEL_RESET = 7'd7;
	localparam int LATENCY = 6;

	// formula numbers
	localparam logic [5:0] F_ZERO = 6'd0, F_HALF = 6'd1, F_ONE = 6'd2, F_LIN = 6'd3,
		F_SQ = 6'd4, F_CUBE = 6'd5, F_QUAD = 6'd6, F_SQRT = 6'd7, F_QRT = 6'd8,
		F_SIN1 = 6'd9, F_COS1 = 6'd10, F_ABSH = 6'd11, F_SQ2 = 6'd12,
		F_SIN2 = 6'd13, F_ACOS2 = 6'd14, F_SIN4 = 6'd15, F_COS4 = 6'd16,
		F_ASIN4 = 6'd17, F_ACOS4 = 6'd18, F_ASIN8 = 6'd19, F_ACOS8 = 6'd20,
		F_3X = 6'd21, F_3XM1 = 6'd22, F_3XM2 = 6'd23, F_A3XM1 = 6'd24,
		F_A3XM2 = 6'd25, F_H3XM1 = 6'd26, F_H3XM2 = 6'd27, F_HA3XM1 = 6'd28,
		F_HA3XM2 = 6'd29, F_RAMP30 = 6'd30, F_RAMP31 = 6'd31, F_RAMP32 = 6'd32,
		F_A2XMH = 6'd33, F_2X = 6'd34, F_2XMH = 6'd35, F_2XM1 = 6'd36,
		F_LAST = 6'd36;

	// per-request control carried down the pipe
	typedef struct packed {
		logic [5:0] fm;
		logic       bad;
	} g2c_ctl_t;
endpackage

// ===== src/gray_to_color_formula.sv =====
`timescale 1ns / 1ps
// channel    | direction | ports
// request    | in / out  | start, gray_level in; busy out
// result     | out       | done, channel_value, bad_formula
// config     | in        | cfg_we, cfg_data (formula_select)
// one request per cycle; the pipe depth is set by the root pipe
// (two chained square roots) and the table sine stages
// busy is held low: the pipe never stalls and results cannot be held off
// arst_n clears the valid bits and loads formula 7
module gray_to_color_formula #(
	parameter int FRACTION_BITS = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [FRACTION_BITS:0] gray_level,
	output logic done,
	output logic [FRACTION_BITS:0] channel_value,
	output logic bad_formula,
	input  logic cfg_we,
	input  logic [g2c_pkg::SEL_W-1:0] cfg_data
);
	import g2c_pkg::*;
	localparam int FB = FRACTION_BITS;
	localparam int W = FB + 8;
	localparam logic signed [W-1:0] ONE = W'(1) << FB;
	localparam logic signed [W-1:0] TWO = ONE << 1;
	localparam logic signed [W-1:0] HALF = ONE >>> 1;
	localparam logic signed [W-1:0] QTR = ONE >>> 2;
	localparam logic signed [W-1:0] K2 = W'(2);
	localparam logic signed [W-1:0] K3 = W'(3);
	localparam logic signed [W-1:0] K4 = W'(4);
	localparam logic signed [W-1:0] K25 = W'(25);
	localparam logic signed [W-1:0] ONE23 = W'(23) * ONE;
	localparam logic signed [W-1:0] D42 = W'((42 * (64'd1 << FB) + 50) / 100);
	localparam logic signed [W-1:0] D57 = W'((57 * (64'd1 << FB) + 50) / 100);
	localparam logic signed [W-1:0] D84 = W'((84 * (64'd1 << FB) + 50) / 100);
	localparam logic signed [W-1:0] D92 = W'((92 * (64'd1 << FB) + 50) / 100);
	localparam logic signed [W-1:0] D184 = W'((184 * (64'd1 << FB) + 50) / 100);

	logic [SEL_W-1:0] sel_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= SEL_RESET;
		else if (cfg_we) sel_q <= cfg_data;
	end
	assign busy = 1'b0;

	// stage 0: saturate, invert, decode
	logic [FB:0] xs;
	logic [SEL_W-1:0] mg;
	assign xs = (gray_level > (FB+1)'(ONE)) ? ONE[FB:0] : gray_level[FB:0];
	assign mg = sel_q[SEL_W-1] ? -sel_q : sel_q;

	logic [LATENCY:1] v_q;
	g2c_ctl_t ctl_p [LATENCY+1];
	logic [FB:0] x_p [LATENCY+1];
	assign ctl_p[0] = '{fm: mg[5:0], bad: (mg > SEL_W'(F_LAST))};
	assign x_p[0] = sel_q[SEL_W-1] ? ONE[FB:0] - xs : xs;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[LATENCY-1:1], start};
	end
	for (genvar s = 0; s < LATENCY; s++) begin : g_pipe
		always_ff @(posedge clk) begin
			ctl_p[s+1] <= ctl_p[s];
			x_p[s+1] <= x_p[s];
		end
	end

	// powers: s1 square, s2 cube and fourth
	logic [2*FB+1:0] sq_full, cu_full, qu_full, sq2_full;
	logic [FB:0] sq_s2, cu_s3, qu_s3, sq2_s2;
	logic [FB:0] sq_s3, sq2_s3, sq_s4, sq2_s4, sq_s5, sq2_s5, cu_s4, qu_s4, cu_s5, qu_s5;
	logic [FB:0] d2_s1;
	logic [FB:0] x2m;
	assign x2m = x_p[0] >= HALF[FB:0] ? (x_p[0] - HALF[FB:0]) << 1 : (HALF[FB:0] - x_p[0]) << 1;
	logic [FB:0] xa_s1;
	always_ff @(posedge clk) begin
		xa_s1 <= x_p[0];
		d2_s1 <= x2m;
	end
	assign sq_full = xa_s1 * xa_s1;
	assign sq2_full = d2_s1 * d2_s1;
	always_ff @(posedge clk) begin
		sq_s2 <= sq_full[2*FB:FB];
		sq2_s2 <= sq2_full[2*FB:FB];
	end
	assign cu_full = sq_s2 * x_p[2];
	assign qu_full = sq_s2 * sq_s2;
	always_ff @(posedge clk) begin
		cu_s3 <= cu_full[2*FB:FB];
		qu_s3 <= qu_full[2*FB:FB];
		sq_s3 <= sq_s2; sq2_s3 <= sq2_s2;
		cu_s4 <= cu_s3; qu_s4 <= qu_s3; sq_s4 <= sq_s3; sq2_s4 <= sq2_s3;
		cu_s5 <= cu_s4; qu_s5 <= qu_s4; sq_s5 <= sq_s4; sq2_s5 <= sq2_s4;
	end

	// roots: two pipes of two stages, result at stage 4
	logic [FB:0] r1, r2;
	g2c_isqrt #(.IW(2*FB+2), .STAGES(2)) u_sqrt1 (
		.clk(clk), .arst_n(arst_n), .radicand({1'b0, x_p[0], FB'(0)}), .root(r1)
	);
	g2c_isqrt #(.IW(2*FB+2), .STAGES(2)) u_sqrt2 (
		.clk(clk), .arst_n(arst_n), .radicand({1'b0, r1, FB'(0)}), .root(r2)
	);
	logic [FB:0] r1_s3, r1_s4, r1_s5, r2_s5;
	always_ff @(posedge clk) begin
		r1_s3 <= r1; r1_s4 <= r1_s3; r1_s5 <= r1_s4;
		r2_s5 <= r2;
	end

	// sine: phase at stage 1, result at stage 4
	logic [FB+1:0] ph;
	logic [FB+4:0] x8;
	always_comb begin
		x8 = (FB+5)'(x_p[1]);
		unique case (ctl_p[1].fm)
			F_SIN1: ph = (FB+2)'(x8);
			F_COS1: ph = (FB+2)'(x8 + (FB+5)'(ONE));
			F_SIN2: ph = (FB+2)'(x8 << 1);
			F_ACOS2: ph = (FB+2)'((x8 << 1) + (FB+5)'(ONE));
			F_SIN4, F_ASIN4: ph = (FB+2)'(x8 << 2);
			F_COS4, F_ACOS4: ph = (FB+2)'((x8 << 2) + (FB+5)'(ONE));
			F_ASIN8: ph = (FB+2)'(x8 << 3);
			F_ACOS8: ph = (FB+2)'((x8 << 3) + (FB+5)'(ONE));
			default: ph = '0;
		endcase
	end
	logic [FB+1:0] ph_s2;
	always_ff @(posedge clk) ph_s2 <= ph;
	logic [FB:0] smag;
	logic sneg;
	g2c_sine #(.FB(FB), .DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.clk(clk), .q(ph_s2), .mag(smag), .neg(sneg)
	);
	logic [FB:0] smag_s5;
	logic sneg_s5;
	always_ff @(posedge clk) begin
		smag_s5 <= smag; sneg_s5 <= sneg;
	end

	// linear formulas at stage 5
	logic signed [W-1:0] lin;
	always_comb begin
		logic signed [W-1:0] x, x3, t;
		x = W'(x_p[5]);
		x3 = K3 * x;
		t = '0;
		unique case (ctl_p[5].fm)
			F_3X: t = x3;
			F_3XM1: t = x3 - ONE;
			F_3XM2: t = x3 - TWO;
			F_A3XM1: t = (x3 < ONE) ? ONE - x3 : x3 - ONE;
			F_A3XM2: t = (x3 < TWO) ? TWO - x3 : x3 - TWO;
			F_H3XM1: t = (x3 - ONE) / K2;
			F_H3XM2: t = (x3 - TWO) / K2;
			F_HA3XM1: t = ((x3 < ONE) ? ONE - x3 : x3 - ONE) >>> 1;
			F_HA3XM2: t = ((x3 < TWO) ? TWO - x3 : x3 - TWO) >>> 1;
			F_RAMP30: t = (x <= QTR) ? '0 : (x >= D57) ? ONE : ((x - QTR) * K25) >>> 3;
			F_RAMP31: t = (x <= D42) ? '0 : (x >= D92) ? ONE : K2 * x - D84;
			F_RAMP32: t = (x <= D42) ? K4 * x : (x <= D92) ? D184 - K2 * x
				: (K25 * x - ONE23) / K2;
			F_A2XMH: t = (K2 * x < HALF) ? HALF - K2 * x : K2 * x - HALF;
			F_2X: t = K2 * x;
			F_2XMH: t = K2 * x - HALF;
			F_2XM1: t = K2 * x - ONE;
			F_ABSH: t = (x < HALF) ? HALF - x : x - HALF;
			default: t = '0;
		endcase
		lin = t;
	end

	// final select and clamp into the output register
	logic signed [W-1:0] vsel;
	always_comb begin
		unique case (ctl_p[5].fm)
			F_ZERO: vsel = '0;
			F_HALF: vsel = HALF;
			F_ONE: vsel = ONE;
			F_LIN: vsel = W'(x_p[5]);
			F_SQ: vsel = W'(sq_s5);
			F_CUBE: vsel = W'(cu_s5);
			F_QUAD: vsel = W'(qu_s5);
			F_SQRT: vsel = W'(r1_s5);
			F_QRT: vsel = W'(r2_s5);
			F_SQ2: vsel = W'(sq2_s5);
			F_SIN1, F_COS1, F_SIN2, F_SIN4, F_COS4:
				vsel = sneg_s5 ? -W'(smag_s5) : W'(smag_s5);
			F_ACOS2, F_ASIN4, F_ACOS4, F_ASIN8, F_ACOS8: vsel = W'(smag_s5);
			default: vsel = lin;
		endcase
		if (ctl_p[5].bad) vsel = '0;
	end
	logic unused_r1;
	assign unused_r1 = ^r1_s5[0] | 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_q[LATENCY-1];
		end
	end
	always_ff @(posedge clk) begin
		channel_value <= vsel < 0 ? '0 : (vsel > ONE) ? (FB+1)'(ONE) : (FB+1)'(vsel);
		bad_formula <= ctl_p[5].bad;
	end
	logic unused_v;
	assign unused_v = v_q[LATENCY] & ctl_p[LATENCY].bad & x_p[LATENCY][0] & unused_r1;
endmodule

// ===== src/g2c_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined floor square root, RB result bits per stage, one request per cycle
module g2c_isqrt #(
	parameter int IW = 34,
	parameter int STAGES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IW-1:0]    radicand,
	output logic [IW/2-1:0]  root
);
	localparam int RW = IW / 2;
	localparam int RB = (RW + STAGES - 1) / STAGES;
	localparam int AW = IW + 2;

	logic [IW-1:0] rem_p [STAGES+1];
	logic [RW-1:0] root_p [STAGES+1];
	logic [IW-1:0] val_p [STAGES+1];

	assign rem_p[0] = '0;
	assign root_p[0] = '0;
	assign val_p[0] = radicand;

	for (genvar s = 0; s < STAGES; s++) begin : g_st
		logic [IW-1:0] rem_c;
		logic [RW-1:0] root_c;
		always_comb begin
			logic [AW-1:0] trial;
			logic [AW-1:0] r2;
			int bi;
			rem_c = rem_p[s];
			root_c = root_p[s];
			for (int k = 0; k < RB; k++) begin
				bi = RW - 1 - (s * RB + k);
				if (bi >= 0) begin
					r2 = {rem_c, val_p[s][2*bi+1 -: 2]};
					trial = {root_c, 2'b01};
					if (r2 >= trial) begin
						r2 = r2 - trial;
						root_c = {root_c[RW-2:0], 1'b1};
					end else begin
						root_c = {root_c[RW-2:0], 1'b0};
					end
					rem_c = r2[IW-1:0];
				end
			end
		end
		logic [IW-1:0] rem_r;
		logic [RW-1:0] root_r;
		logic [IW-1:0] val_r;
		always_ff @(posedge clk) begin
			rem_r <= rem_c;
			root_r <= root_c;
			val_r <= val_p[s];
		end
		assign rem_p[s+1] = rem_r;
		assign root_p[s+1] = root_r;
		assign val_p[s+1] = val_r;
	end

	assign root = root_p[STAGES];

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

// ===== src/g2c_sine.sv =====
`timescale 1ns / 1ps
// quarter-wave table sine over q quarter turns, two registered stages
module g2c_sine #(
	parameter int FB = 16,
	parameter int DEPTH = 256
) (
	input  logic              clk,
	input  logic [FB+1:0]     q,
	output logic [FB:0]       mag,
	output logic              neg
);
	localparam int DB = $clog2(DEPTH);
	localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

	// q30 taylor series of sin, rounded to FB fraction bits
	function automatic logic [FB:0] rom(input int k);
		longint unsigned a, a2, mg, v;
		longint sum;
		a = (64'd1686629713 * 64'(k)) / 64'(DEPTH);
		a2 = (a * a) >> 30;
		mg = a;
		sum = longint'(a);
		for (int n = 1; n <= 10; n++) begin
			mg = ((mg * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) sum = sum - longint'(mg);
			else sum = sum + longint'(mg);
		end
		if (sum < 0) sum = 0;
		v = ((64'(sum) << FB) + 64'd536870912) >> 30;
		if (v > (64'd1 << FB)) v = 64'd1 << FB;
		rom = (FB+1)'(v);
	endfunction

	logic [FB:0] tbl [DEPTH+1];
	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		assign tbl[k] = rom(k);
	end

	logic [1:0] quad;
	logic [FB:0] frac;
	logic [FB+DB:0] pos;
	logic [DB:0] idx;
	logic [FB-1:0] f;
	logic top;
	assign quad = q[FB+1:FB];
	assign frac = quad[0] ? ONE - {1'b0, q[FB-1:0]} : {1'b0, q[FB-1:0]};
	assign pos = (FB+DB+1)'(frac) * (FB+DB+1)'(DEPTH);
	assign idx = pos[FB+DB:FB];
	assign f = pos[FB-1:0];
	assign top = idx >= (DB+1)'(DEPTH);

	logic [FB:0] lo_s1, hi_s1;
	logic [FB-1:0] f_s1;
	logic top_s1, neg_s1;
	always_ff @(posedge clk) begin
		top_s1 <= top;
		lo_s1 <= tbl[idx];
		hi_s1 <= tbl[top ? idx : idx + (DB+1)'(1)];
		f_s1 <= f;
		neg_s1 <= quad[1];
	end

	logic [FB:0] d;
	logic [2*FB:0] prod;
	assign d = hi_s1 >= lo_s1 ? hi_s1 - lo_s1 : '0;
	assign prod = d * f_s1;
	always_ff @(posedge clk) begin
		mag <= top_s1 ? lo_s1 : lo_s1 + prod[2*FB:FB];
		neg <= neg_s1;
	end
endmodule

// ===== src/g2c_checker.sv =====
`timescale 1ns / 1ps
`include "gray_to_color_formula_defines.svh"
module g2c_assertions (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [16:0] channel_value,
	input logic bad_formula
);
	import g2c_pkg::*;
	`G2C_ASSERT_LAT(a_done_lat, start && !busy, LATENCY, done)
	`G2C_ASSERT_IMP(a_bad_zero, done && bad_formula, channel_value == '0)
	`G2C_ASSERT_IMP(a_range, done, channel_value <= 17'h10000)
	`G2C_ASSERT_LAT(a_no_spurious, !start, LATENCY, !done)
endmodule

bind gray_to_color_formula g2c_assertions u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.channel_value(channel_value), .bad_formula(bad_formula)
);
